// ----- rtl/sixdec_pkg.sv -----
`timescale 1ns / 1ps
// sixdec_pkg: shared types, constants and helpers of the sixel stream decoder
package sixdec_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int IDX_W       = $clog2(PAL_ENTRIES + 1);
	localparam int COORD_W     = 16;
	localparam int NUM_W       = 16;
	localparam int RGB_W       = 24;
	localparam int BAND_ROWS   = 6;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [RGB_W-1:0] RGB_WHITE = {RGB_W{1'b1}};
	localparam logic [RGB_W-1:0] RGB_BLACK = '0;

	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	localparam logic [NUM_W-1:0] MODE_RGB = 16'd2;

	localparam logic       KIND_WRITE  = 1'b0;
	localparam logic       KIND_FINISH = 1'b1;

	// x / 100 for x below 2^24 as (x * RECIP_100) >> LVL_SHIFT
	localparam int               LVL_SHIFT = 31;
	localparam logic [24:0]      RECIP_100 = 25'd21474837;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_INDEX  = 7'b0000010,
		PH_MODE   = 7'b0000100,
		PH_RED    = 7'b0001000,
		PH_GREEN  = 7'b0010000,
		PH_BLUE   = 7'b0100000,
		PH_REPEAT = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} byte_t;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] top_row;
		logic [5:0]         row_mask;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [NUM_W-1:0]   run_length;
		logic [COORD_W-1:0] image_width;
		logic [COORD_W-1:0] image_height;
		logic               end_of_run;
	} res_t;

	typedef struct packed {
		logic a_valid;
		logic b_valid;
		res_t a;
		res_t b;
	} push_t;

	function automatic logic [7:0] pct_level(input logic [NUM_W-1:0] p);
		logic [23:0] scaled;
		logic [48:0] prod;
		scaled = {p, 8'h00} - {8'h00, p};
		prod   = {25'd0, scaled} * {24'd0, RECIP_100};
		return prod[LVL_SHIFT+7:LVL_SHIFT];
	endfunction

	function automatic logic [NUM_W-1:0] dec_push(input logic [NUM_W-1:0] acc,
		input logic [3:0] d);
		logic [NUM_W+3:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (NUM_W+4)'(d);
		return (v > (NUM_W+4)'({NUM_W{1'b1}})) ? {NUM_W{1'b1}} : v[NUM_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_push(input logic [IDX_W-1:0] acc,
		input logic [3:0] d);
		logic [IDX_W+3:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (IDX_W+4)'(d);
		return (v > (IDX_W+4)'(PAL_ENTRIES)) ? IDX_W'(PAL_ENTRIES) : v[IDX_W-1:0];
	endfunction

endpackage

// ----- rtl/sixdec_outq.sv -----
`timescale 1ns / 1ps
// sixdec_outq: small result queue taking up to two results per cycle
module sixdec_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  sixdec_pkg::push_t  push,
	output logic               room,
	output logic               res_valid,
	input  logic               res_stall,
	output sixdec_pkg::res_t   res_data
);

	sixdec_pkg::res_t                 q_mem [sixdec_pkg::QDEPTH];
	logic [sixdec_pkg::QAW-1:0]       wptr_q;
	logic [sixdec_pkg::QAW-1:0]       rptr_q;
	logic [sixdec_pkg::QAW:0]         count_q;
	logic                             pop;
	logic [sixdec_pkg::QAW:0]         npush;

	assign res_valid = (count_q != '0);
	assign res_data  = q_mem[rptr_q];
	assign pop       = res_valid && !res_stall;
	assign room      = (count_q <= (sixdec_pkg::QAW+1)'(sixdec_pkg::QDEPTH - 2));
	assign npush     = (sixdec_pkg::QAW+1)'(push.a_valid) + (sixdec_pkg::QAW+1)'(push.b_valid);

	always_ff @(posedge clk) begin
		if (push.a_valid)
			q_mem[wptr_q] <= push.a;
		if (push.b_valid)
			q_mem[sixdec_pkg::QAW'(wptr_q + 1'b1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= sixdec_pkg::QAW'(wptr_q + npush);
			if (pop)
				rptr_q <= sixdec_pkg::QAW'(rptr_q + 1'b1);
			count_q <= count_q + npush - (sixdec_pkg::QAW+1)'(pop);
		end
	end

endmodule

// ----- rtl/sixel_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// sixel_stream_decoder_unit: sixel byte parser with palette memory and result queue
//
//   channel  signals                          moves
//   byte     byte_valid byte_stall byte_data  one stream byte and end marker
//   res      res_valid  res_stall  res_data   column write or image finish
//
// one byte per cycle while byte_stall is low; the parse state updates in the accept cycle and the
// palette read started there returns in the next cycle, with same-cycle writes forwarded
// a byte's results pass through the s1 registers into the result queue, up to two per byte
// a final byte that paints takes two queue slots; byte_stall rises only when the queue is
// nearly full
// reset and the final byte clear the palette through per-entry valid bits, no clearing pass
module sixel_stream_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  sixdec_pkg::byte_t   byte_data,
	output logic                res_valid,
	input  logic                res_stall,
	output sixdec_pkg::res_t    res_data
);

	localparam int AW = sixdec_pkg::PAL_AW;
	localparam int CW = sixdec_pkg::COORD_W;
	localparam int NW = sixdec_pkg::NUM_W;

	sixdec_pkg::phase_t         phase_q, phase_n;
	logic [sixdec_pkg::IDX_W-1:0] idx_acc_q, idx_acc_n;
	logic [NW-1:0]              num_acc_q, num_acc_n;
	logic [7:0]                 red_lvl_q, red_lvl_n;
	logic [7:0]                 green_lvl_q, green_lvl_n;
	logic [AW-1:0]              cur_color_q, cur_color_n;
	logic [CW-1:0]              cursor_q, cursor_n;
	logic [CW-1:0]              band_q, band_n;
	logic [CW-1:0]              widest_q, widest_n;
	logic [sixdec_pkg::PAL_ENTRIES-1:0] pal_valid_q;

	logic [sixdec_pkg::RGB_W-1:0] pal_mem [sixdec_pkg::PAL_ENTRIES];
	logic [sixdec_pkg::RGB_W-1:0] rd_q;

	logic                       accept;
	logic                       last;
	logic [7:0]                 b;
	logic [7:0]                 dsub, msub;
	logic                       digit, sixel;
	logic [3:0]                 dval;
	logic [AW-1:0]              idx_clamp;
	logic [7:0]                 lvl;
	logic                       do_idle;
	logic                       paint;
	logic [NW-1:0]              run;
	logic [CW:0]                cur_sum, band_sum, hgt_sum;
	logic                       wr_en;
	logic [AW-1:0]              wr_idx;
	logic [sixdec_pkg::RGB_W-1:0] wr_data;
	logic [CW-1:0]              fin_width, fin_height;

	logic                       valid_s1;
	logic                       paint_s1, fin_s1;
	logic [CW-1:0]              column_s1, top_s1;
	logic [5:0]                 mask_s1;
	logic [NW-1:0]              run_s1;
	logic [CW-1:0]              width_s1, height_s1;
	logic                       fwd_s1, pv_s1, zero_s1;
	logic [sixdec_pkg::RGB_W-1:0] fwd_data_s1;
	logic [sixdec_pkg::RGB_W-1:0] rgb_s1;

	logic                       room;
	logic                       go;
	sixdec_pkg::push_t          push;
	sixdec_pkg::res_t           wr_res, fin_res;

	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;
	assign b          = byte_data.data_byte;
	assign last       = byte_data.end_of_data;
	assign dsub       = b - sixdec_pkg::CH_ZERO;
	assign msub       = b - sixdec_pkg::CH_QMARK;
	assign dval       = dsub[3:0];
	assign digit      = (b >= sixdec_pkg::CH_ZERO) && (b <= sixdec_pkg::CH_NINE);
	assign sixel      = (b >= sixdec_pkg::CH_QMARK) && (b <= sixdec_pkg::CH_TILDE);
	assign idx_clamp  = (idx_acc_q < sixdec_pkg::IDX_W'(sixdec_pkg::PAL_ENTRIES)) ?
		idx_acc_q[AW-1:0] : '0;
	assign lvl        = sixdec_pkg::pct_level(num_acc_q);

	always_comb begin
		phase_n     = phase_q;
		idx_acc_n   = idx_acc_q;
		num_acc_n   = num_acc_q;
		red_lvl_n   = red_lvl_q;
		green_lvl_n = green_lvl_q;
		cur_color_n = cur_color_q;
		band_n      = band_q;
		do_idle     = 1'b0;
		paint       = 1'b0;
		run         = NW'(1);
		wr_en       = 1'b0;
		wr_idx      = idx_clamp;
		wr_data     = {red_lvl_q, green_lvl_q, lvl};
		cur_sum     = '0;
		band_sum    = '0;
		hgt_sum     = '0;
		cursor_n    = cursor_q;
		widest_n    = widest_q;

		unique case (phase_q)
			sixdec_pkg::PH_INDEX: begin
				if (digit) begin
					idx_acc_n = sixdec_pkg::idx_push(idx_acc_q, dval);
				end else if (b == sixdec_pkg::CH_SEMI) begin
					phase_n   = sixdec_pkg::PH_MODE;
					num_acc_n = '0;
				end else begin
					cur_color_n = idx_clamp;
					phase_n     = sixdec_pkg::PH_IDLE;
					do_idle     = 1'b1;
				end
			end
			sixdec_pkg::PH_MODE: begin
				if (digit) begin
					num_acc_n = sixdec_pkg::dec_push(num_acc_q, dval);
				end else if (num_acc_q == sixdec_pkg::MODE_RGB && b == sixdec_pkg::CH_SEMI) begin
					phase_n   = sixdec_pkg::PH_RED;
					num_acc_n = '0;
				end else begin
					cur_color_n = idx_clamp;
					phase_n     = sixdec_pkg::PH_IDLE;
					do_idle     = 1'b1;
				end
			end
			sixdec_pkg::PH_RED: begin
				if (digit) begin
					num_acc_n = sixdec_pkg::dec_push(num_acc_q, dval);
				end else begin
					red_lvl_n = lvl;
					num_acc_n = '0;
					phase_n   = sixdec_pkg::PH_GREEN;
				end
			end
			sixdec_pkg::PH_GREEN: begin
				if (digit) begin
					num_acc_n = sixdec_pkg::dec_push(num_acc_q, dval);
				end else begin
					green_lvl_n = lvl;
					num_acc_n   = '0;
					phase_n     = sixdec_pkg::PH_BLUE;
				end
			end
			sixdec_pkg::PH_BLUE: begin
				if (digit) begin
					num_acc_n = sixdec_pkg::dec_push(num_acc_q, dval);
				end else begin
					wr_en       = 1'b1;
					cur_color_n = idx_clamp;
					phase_n     = sixdec_pkg::PH_IDLE;
					do_idle     = 1'b1;
				end
			end
			sixdec_pkg::PH_REPEAT: begin
				if (digit) begin
					num_acc_n = sixdec_pkg::dec_push(num_acc_q, dval);
				end else begin
					phase_n = sixdec_pkg::PH_IDLE;
					paint   = sixel;
					run     = (num_acc_q == '0) ? NW'(1) : num_acc_q;
				end
			end
			default: begin
				phase_n = sixdec_pkg::PH_IDLE;
				do_idle = 1'b1;
			end
		endcase

		if (do_idle) begin
			priority if (b == sixdec_pkg::CH_HASH) begin
				phase_n   = sixdec_pkg::PH_INDEX;
				idx_acc_n = '0;
			end else if (b == sixdec_pkg::CH_DASH) begin
				band_sum = {1'b0, band_q} + (CW+1)'(sixdec_pkg::BAND_ROWS);
				band_n   = band_sum[CW] ? {CW{1'b1}} : band_sum[CW-1:0];
				cursor_n = '0;
			end else if (b == sixdec_pkg::CH_DOLLAR) begin
				cursor_n = '0;
			end else if (b == sixdec_pkg::CH_BANG) begin
				phase_n   = sixdec_pkg::PH_REPEAT;
				num_acc_n = '0;
			end else if (sixel) begin
				paint = 1'b1;
				run   = NW'(1);
			end else begin
				phase_n = sixdec_pkg::PH_IDLE;
			end
		end

		if (paint) begin
			cur_sum  = {1'b0, cursor_q} + (CW+1)'(run);
			cursor_n = cur_sum[CW] ? {CW{1'b1}} : cur_sum[CW-1:0];
			widest_n = (cursor_n > widest_q) ? cursor_n : widest_q;
		end

		hgt_sum    = {1'b0, band_n} + (CW+1)'(sixdec_pkg::BAND_ROWS);
		fin_height = hgt_sum[CW] ? {CW{1'b1}} : hgt_sum[CW-1:0];
		fin_width  = (widest_n == '0) ? CW'(1) : widest_n;
	end

	// palette memory: write and read in the accept cycle
	always_ff @(posedge clk) begin
		if (accept && wr_en && !last)
			pal_mem[wr_idx] <= wr_data;
		if (accept)
			rd_q <= pal_mem[cur_color_n];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sixdec_pkg::PH_IDLE;
			idx_acc_q   <= '0;
			num_acc_q   <= '0;
			red_lvl_q   <= '0;
			green_lvl_q <= '0;
			cur_color_q <= '0;
			cursor_q    <= '0;
			band_q      <= '0;
			widest_q    <= '0;
			pal_valid_q <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q     <= sixdec_pkg::PH_IDLE;
				idx_acc_q   <= '0;
				num_acc_q   <= '0;
				red_lvl_q   <= '0;
				green_lvl_q <= '0;
				cur_color_q <= '0;
				cursor_q    <= '0;
				band_q      <= '0;
				widest_q    <= '0;
				pal_valid_q <= '0;
			end else begin
				phase_q     <= phase_n;
				idx_acc_q   <= idx_acc_n;
				num_acc_q   <= num_acc_n;
				red_lvl_q   <= red_lvl_n;
				green_lvl_q <= green_lvl_n;
				cur_color_q <= cur_color_n;
				cursor_q    <= cursor_n;
				band_q      <= band_n;
				widest_q    <= widest_n;
				if (wr_en)
					pal_valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (room) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			paint_s1    <= paint;
			fin_s1      <= last;
			column_s1   <= cursor_q;
			top_s1      <= band_q;
			mask_s1     <= msub[5:0];
			run_s1      <= run;
			width_s1    <= fin_width;
			height_s1   <= fin_height;
			fwd_s1      <= wr_en && (wr_idx == cur_color_n);
			fwd_data_s1 <= wr_data;
			pv_s1       <= pal_valid_q[cur_color_n];
			zero_s1     <= (cur_color_n == '0);
		end
	end

	always_comb begin
		priority if (fwd_s1)
			rgb_s1 = fwd_data_s1;
		else if (pv_s1)
			rgb_s1 = rd_q;
		else if (zero_s1)
			rgb_s1 = sixdec_pkg::RGB_WHITE;
		else
			rgb_s1 = sixdec_pkg::RGB_BLACK;
	end

	always_comb begin
		wr_res              = '0;
		wr_res.kind         = sixdec_pkg::KIND_WRITE;
		wr_res.column       = column_s1;
		wr_res.top_row      = top_s1;
		wr_res.row_mask     = mask_s1;
		wr_res.red          = rgb_s1[23:16];
		wr_res.green        = rgb_s1[15:8];
		wr_res.blue         = rgb_s1[7:0];
		wr_res.run_length   = run_s1;
		wr_res.end_of_run   = !fin_s1;

		fin_res              = '0;
		fin_res.kind         = sixdec_pkg::KIND_FINISH;
		fin_res.image_width  = width_s1;
		fin_res.image_height = height_s1;
		fin_res.end_of_run   = 1'b1;
	end

	assign go           = valid_s1 && room;
	assign push.a_valid = go && (paint_s1 || fin_s1);
	assign push.b_valid = go && paint_s1 && fin_s1;
	assign push.a       = paint_s1 ? wr_res : fin_res;
	assign push.b       = fin_res;

	sixdec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

`ifndef NO_ASSERTIONS
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> phase_q == sixdec_pkg::PH_IDLE && cursor_q == '0 &&
		pal_valid_q == '0)
		else $error("final byte did not return the decoder to its reset state");

	a_widest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		widest_q >= cursor_q)
		else $error("cursor beyond widest column");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == sixdec_pkg::KIND_FINISH |-> res_data.end_of_run)
		else $error("finish result without end_of_run");
`endif

endmodule
